FILE: src/egcd_pkg.sv
// Shared constants and types for the extended GCD block.
`default_nettype none

package egcd_pkg;

  // Default datapath width: operands are one bit narrower, coefficients full width.
  localparam int unsigned DefaultDataWidth = 32;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StCheck  = 3'b010,
    StDivide = 3'b100
  } state_e;

endpackage

`default_nettype wire

FILE: src/extended_gcd_bezout_top.sv
// Top level of the extended GCD block: sequencer, remainder and coefficient registers.
// Usage:
//   Command channel: an item (value_a_i, value_b_i) is taken at a rising edge
//   where start is high and busy is low. busy stays high while the item runs.
//   Result channel: divisor_o, coef_a_o, coef_b_o are valid for exactly one
//   cycle while done_o is high; the receiver cannot stall, so the result must
//   be captured in that cycle. value_a_i * coef_a_o + value_b_i * coef_b_o
//   equals divisor_o (coefficients in two's complement).
// Sequencing: after accept, the block alternates between a check state and a
//   divide state for each Euclid division step (none when value_b_i is zero).
//   Each step is one pass of the shared restoring divider, one quotient bit per
//   cycle, plus a check and a row update.
// Throughput: one item at a time; a new item may be started in the cycle
//   that done_o is high, since busy is already low then.
// Reset: asynchronous, active low; returns to idle and drops done_o. Any item
//   in progress is lost.
`default_nettype none

module extended_gcd_bezout_top #(
  parameter int unsigned DATA_WIDTH = egcd_pkg::DefaultDataWidth
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic        [DATA_WIDTH-2:0] value_a_i,
  input  wire logic        [DATA_WIDTH-2:0] value_b_i,
  output logic                              done_o,
  output logic             [DATA_WIDTH-2:0] divisor_o,
  output logic signed      [DATA_WIDTH-1:0] coef_a_o,
  output logic signed      [DATA_WIDTH-1:0] coef_b_o
);

  egcd_pkg::state_e state_q, state_d;

  logic [DATA_WIDTH-2:0] rem_prev_q, rem_prev_d;
  logic [DATA_WIDTH-2:0] rem_cur_q, rem_cur_d;
  logic [DATA_WIDTH-1:0] xa_prev_q, xa_prev_d;
  logic [DATA_WIDTH-1:0] xa_cur_q, xa_cur_d;
  logic [DATA_WIDTH-1:0] xb_prev_q, xb_prev_d;
  logic [DATA_WIDTH-1:0] xb_cur_q, xb_cur_d;
  logic                  done_q, done_d;
  logic [DATA_WIDTH-2:0] divisor_q, divisor_d;
  logic [DATA_WIDTH-1:0] coef_a_q, coef_a_d;
  logic [DATA_WIDTH-1:0] coef_b_q, coef_b_d;

  logic                  div_start;
  logic                  div_done;
  logic [DATA_WIDTH-2:0] div_rem;
  logic [DATA_WIDTH-1:0] div_prod_a;
  logic [DATA_WIDTH-1:0] div_prod_b;
  logic                  accept;

  assign accept = start && !busy;

  // Shared divide / multiply-accumulate unit
  egcd_divider #(
    .DataWidth (DATA_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rem_prev_q),
    .divisor_i  (rem_cur_q),
    .mult_a_i   (xa_cur_q),
    .mult_b_i   (xb_cur_q),
    .done_o     (div_done),
    .rem_o      (div_rem),
    .prod_a_o   (div_prod_a),
    .prod_b_o   (div_prod_b)
  );

  // Sequencer
  always_comb begin
    state_d    = state_q;
    rem_prev_d = rem_prev_q;
    rem_cur_d  = rem_cur_q;
    xa_prev_d  = xa_prev_q;
    xa_cur_d   = xa_cur_q;
    xb_prev_d  = xb_prev_q;
    xb_cur_d   = xb_cur_q;
    done_d     = 1'b0;
    divisor_d  = divisor_q;
    coef_a_d   = coef_a_q;
    coef_b_d   = coef_b_q;
    div_start  = 1'b0;
    unique case (state_q)
      egcd_pkg::StIdle: begin
        if (accept) begin
          rem_prev_d = value_a_i;
          rem_cur_d  = value_b_i;
          xa_prev_d  = DATA_WIDTH'(1);
          xa_cur_d   = '0;
          xb_prev_d  = '0;
          xb_cur_d   = DATA_WIDTH'(1);
          state_d    = egcd_pkg::StCheck;
        end
      end
      egcd_pkg::StCheck: begin
        if (rem_cur_q == '0) begin
          // Remainder exhausted: previous row holds the answer
          done_d    = 1'b1;
          divisor_d = rem_prev_q;
          coef_a_d  = xa_prev_q;
          coef_b_d  = xb_prev_q;
          state_d   = egcd_pkg::StIdle;
        end else begin
          div_start = 1'b1;
          state_d   = egcd_pkg::StDivide;
        end
      end
      egcd_pkg::StDivide: begin
        if (div_done) begin
          // Shift rows: new coefficient = prev - q * cur
          rem_prev_d = rem_cur_q;
          rem_cur_d  = div_rem;
          xa_prev_d  = xa_cur_q;
          xa_cur_d   = xa_prev_q - div_prod_a;
          xb_prev_d  = xb_cur_q;
          xb_cur_d   = xb_prev_q - div_prod_b;
          state_d    = egcd_pkg::StCheck;
        end
      end
      default: begin
        state_d = egcd_pkg::StIdle;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= egcd_pkg::StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Working rows and result registers
  always_ff @(posedge clk_i) begin
    rem_prev_q <= rem_prev_d;
    rem_cur_q  <= rem_cur_d;
    xa_prev_q  <= xa_prev_d;
    xa_cur_q   <= xa_cur_d;
    xb_prev_q  <= xb_prev_d;
    xb_cur_q   <= xb_cur_d;
    divisor_q  <= divisor_d;
    coef_a_q   <= coef_a_d;
    coef_b_q   <= coef_b_d;
  end

  assign busy      = (state_q != egcd_pkg::StIdle);
  assign done_o    = done_q;
  assign divisor_o = divisor_q;
  assign coef_a_o  = coef_a_q;
  assign coef_b_o  = coef_b_q;

`ifndef NO_ASSERTIONS
  // Result strobe only once the sequencer is back in idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("done_o while busy");

  // Result strobe lasts a single cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("done_o held longer than one cycle");

  // An accepted item makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> busy)
    else $error("item accepted but block not busy");

  // Divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == egcd_pkg::StDivide))
    else $error("divider done outside divide state");

  // Divider is launched only for a nonzero divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (rem_cur_q != '0))
    else $error("divider started with zero divisor");
`endif

endmodule

`default_nettype wire

FILE: src/egcd_divider.sv
// Iterative restoring divider that also accumulates quotient times two multiplicands.
`default_nettype none

module egcd_divider #(
  parameter int unsigned DataWidth = egcd_pkg::DefaultDataWidth
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [DataWidth-2:0]   dividend_i,
  input  wire logic [DataWidth-2:0]   divisor_i,
  input  wire logic [DataWidth-1:0]   mult_a_i,
  input  wire logic [DataWidth-1:0]   mult_b_i,
  output logic                        done_o,
  output logic      [DataWidth-2:0]   rem_o,
  output logic      [DataWidth-1:0]   prod_a_o,
  output logic      [DataWidth-1:0]   prod_b_o
);

  localparam int unsigned OpWidth  = DataWidth - 1;
  localparam int unsigned CntWidth = $clog2(OpWidth);
  localparam logic [CntWidth-1:0] LastCnt = CntWidth'(OpWidth - 1);

  logic                run_q, run_d;
  logic                done_q, done_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic [OpWidth-1:0]  part_q, part_d;
  logic [OpWidth-1:0]  quo_q, quo_d;
  logic [DataWidth-1:0] acc_a_q, acc_a_d;
  logic [DataWidth-1:0] acc_b_q, acc_b_d;

  logic [OpWidth:0]    trial;
  logic [OpWidth:0]    diff;
  logic                fits;

  // One quotient bit per cycle, MSB first
  assign trial = {part_q, quo_q[OpWidth-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = (trial >= {1'b0, divisor_i});

  // Sequencing and datapath next values
  always_comb begin
    run_d   = run_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    part_d  = part_q;
    quo_d   = quo_q;
    acc_a_d = acc_a_q;
    acc_b_d = acc_b_q;
    if (start_i) begin
      run_d   = 1'b1;
      cnt_d   = LastCnt;
      part_d  = '0;
      quo_d   = dividend_i;
      acc_a_d = '0;
      acc_b_d = '0;
    end else if (run_q) begin
      part_d  = fits ? diff[OpWidth-1:0] : trial[OpWidth-1:0];
      quo_d   = {quo_q[OpWidth-2:0], 1'b0};
      // Horner form of q * mult, kept modulo 2^DataWidth
      acc_a_d = {acc_a_q[DataWidth-2:0], 1'b0} + (fits ? mult_a_i : '0);
      acc_b_d = {acc_b_q[DataWidth-2:0], 1'b0} + (fits ? mult_b_i : '0);
      cnt_d   = cnt_q - CntWidth'(1);
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    part_q  <= part_d;
    quo_q   <= quo_d;
    acc_a_q <= acc_a_d;
    acc_b_q <= acc_b_d;
  end

  assign done_o   = done_q;
  assign rem_o    = part_q;
  assign prod_a_o = acc_a_q;
  assign prod_b_o = acc_b_q;

endmodule

`default_nettype wire

FILE: bench/tb_extended_gcd_bezout_top.sv
// Self-checking testbench for the extended GCD block: random and corner operand pairs.
`timescale 1ns / 1ps

module tb_extended_gcd_bezout_top;

  localparam int unsigned DataWidth  = egcd_pkg::DefaultDataWidth;
  localparam int unsigned OpW        = DataWidth - 1;
  localparam int unsigned CfW        = DataWidth;
  localparam int          NumRandom  = 1575;
  localparam int          QuietTail  = 200;
  localparam int          SettleCyc  = 1600;    // longest chain: about 45 Euclid steps
  localparam longint      CycleLimit = 20_000_000;
  localparam int          MaxReports = 10;

  // one operand pair plus how the sender treats it
  typedef struct packed {
    logic [OpW-1:0] a;
    logic [OpW-1:0] b;
    logic [3:0]     gap;      // idle cycles before this item
    logic           drain;    // hold off until nothing is outstanding
  } pair_t;

  // gcd with Bezout coefficients, plus the Euclid step count for the summary
  typedef struct packed {
    logic [OpW-1:0]        divisor;
    logic signed [CfW-1:0] coef_a;
    logic signed [CfW-1:0] coef_b;
    logic [7:0]            steps;
  } bezout_t;

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  start   = 1'b0;
  logic [OpW-1:0]        value_a = '0;
  logic [OpW-1:0]        value_b = '0;
  logic                  busy;
  logic                  done_o;
  logic [OpW-1:0]        divisor_o;
  logic signed [CfW-1:0] coef_a_o;
  logic signed [CfW-1:0] coef_b_o;

  pair_t   pending_pairs[$];
  bezout_t bezout_due[$];
  int      n_taken    = 0;
  int      n_seen     = 0;
  int      idle_left  = 0;
  int      mismatches = 0;
  int      deepest    = 0;
  int      n_zero_op  = 0;
  longint  cycles     = 0;

  extended_gcd_bezout_top #(
    .DATA_WIDTH(DataWidth)
  ) u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .value_a_i(value_a),
    .value_b_i(value_b),
    .done_o   (done_o),
    .divisor_o(divisor_o),
    .coef_a_o (coef_a_o),
    .coef_b_o (coef_b_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Euclid with two coefficient pairs; 64-bit signed keeps products exact
  function automatic bezout_t euclid_bezout(input logic [OpW-1:0] a, input logic [OpW-1:0] b);
    bezout_t        res;
    logic [OpW-1:0] r_prev, r_cur, r_next, quot;
    longint         x_prev, x_cur, y_prev, y_cur, tmp;
    int             steps;
    r_prev = a;
    r_cur  = b;
    x_prev = 1;
    x_cur  = 0;
    y_prev = 0;
    y_cur  = 1;
    steps  = 0;
    while (r_cur != '0) begin
      quot   = r_prev / r_cur;
      r_next = r_prev % r_cur;
      tmp    = x_prev - longint'(quot) * x_cur;
      x_prev = x_cur;
      x_cur  = tmp;
      tmp    = y_prev - longint'(quot) * y_cur;
      y_prev = y_cur;
      y_cur  = tmp;
      r_prev = r_cur;
      r_cur  = r_next;
      steps++;
    end
    res.divisor = r_prev;
    res.coef_a  = x_prev[CfW-1:0];
    res.coef_b  = y_prev[CfW-1:0];
    res.steps   = steps[7:0];
    return res;
  endfunction

  // operand of a random bit length, mostly short to keep chains cheap
  function automatic logic [OpW-1:0] rand_operand();
    int unsigned bits;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      bits = $urandom_range(1, 12);
    end else if (pick < 9) begin
      bits = $urandom_range(13, 24);
    end else begin
      bits = $urandom_range(25, OpW);
    end
    return OpW'($urandom & ((32'h1 << bits) - 1));
  endfunction

  function automatic void queue_pair(input logic [OpW-1:0] a, input logic [OpW-1:0] b,
                                     input int unsigned gap, input logic drain);
    pair_t p;
    p.a     = a;
    p.b     = b;
    p.gap   = gap[3:0];
    p.drain = drain;
    pending_pairs.push_back(p);
  endfunction

  // sender: one pair per start/busy handshake
  always @(posedge clk_i) begin : drive_proc
    pair_t nxt;
    bit    fire;
    int    outstanding;
    if (rst_ni) begin
      fire = start && !busy;
      if (fire) begin
        bezout_due.push_back(euclid_bezout(value_a, value_b));
        if (bezout_due[$].steps > deepest) deepest = bezout_due[$].steps;
        if (value_a == '0 || value_b == '0) n_zero_op++;
        n_taken++;
        if (pending_pairs.size() != 0) idle_left = pending_pairs[0].gap;
      end
      outstanding = n_taken - n_seen - (done_o ? 1 : 0);
      if (start && !fire) begin
        // hold the current item until busy drops
      end else if (idle_left > 0) begin
        idle_left--;
        start   <= 1'b0;
        value_a <= OpW'($urandom);
        value_b <= OpW'($urandom);
      end else if (pending_pairs.size() != 0 &&
                   !(pending_pairs[0].drain && outstanding != 0)) begin
        nxt = pending_pairs.pop_front();
        start   <= 1'b1;
        value_a <= nxt.a;
        value_b <= nxt.b;
      end else begin
        start   <= 1'b0;
        value_a <= OpW'($urandom);
        value_b <= OpW'($urandom);
      end
    end
  end

  // result check: done_o is a one-cycle strobe
  always @(posedge clk_i) begin : check_proc
    bezout_t want;
    if (rst_ni && done_o) begin
      n_seen <= n_seen + 1;
      if (bezout_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("tb: unexpected result gcd=%0d x=%0d y=%0d", divisor_o, coef_a_o, coef_b_o);
      end else begin
        want = bezout_due.pop_front();
        if (divisor_o !== want.divisor || coef_a_o !== want.coef_a ||
            coef_b_o !== want.coef_b) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("tb: mismatch exp gcd=%0d x=%0d y=%0d got gcd=%0d x=%0d y=%0d",
                     want.divisor, want.coef_a, want.coef_b,
                     divisor_o, coef_a_o, coef_b_o);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stim_proc
    logic [OpW-1:0] max_op;
    logic [OpW-1:0] a, b;
    int unsigned    kind, gap, fa, fb, fc, n;
    logic           drain;
    max_op = '1;

    // directed: zero operands, extremes, worst-case Fibonacci chain, alternating bits
    queue_pair('0, '0, 0, 1'b0);
    queue_pair(OpW'(5), '0, 0, 1'b0);
    queue_pair('0, OpW'(7), 0, 1'b0);
    queue_pair(max_op, '0, 0, 1'b0);
    queue_pair('0, max_op, 0, 1'b0);
    queue_pair(max_op, max_op, 0, 1'b0);
    queue_pair(max_op, OpW'(1), 0, 1'b0);
    queue_pair(OpW'(1), max_op, 0, 1'b0);
    queue_pair(max_op, max_op - 1, 0, 1'b0);
    queue_pair(max_op - 1, max_op, 0, 1'b0);
    queue_pair(OpW'(1836311903), OpW'(1134903170), 0, 1'b0);
    queue_pair(OpW'(1134903170), OpW'(1836311903), 0, 1'b0);
    queue_pair(OpW'(1), OpW'(1), 0, 1'b0);
    queue_pair(OpW'(1), '0, 0, 1'b0);
    queue_pair('0, OpW'(1), 0, 1'b0);
    queue_pair(OpW'(240), OpW'(46), 0, 1'b0);
    queue_pair(OpW'(12), OpW'(18), 0, 1'b0);
    queue_pair(OpW'(32'h4000_0000), OpW'(32'h2000_0000), 0, 1'b0);
    queue_pair(OpW'(32'h5555_5555), OpW'(32'h2AAA_AAAA), 0, 1'b0);
    queue_pair(max_op, OpW'(2147483629), 0, 1'b0);
    queue_pair(OpW'(1000000007), OpW'(998244353), 0, 1'b0);

    // random pairs: segments with and without sender gaps, quiet tail
    for (int i = 0; i < NumRandom; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 4) begin
        a = ($urandom_range(0, 1) != 0) ? rand_operand() : '0;
        b = '0;
      end else if (kind < 8) begin
        a = rand_operand();
        b = a;
      end else if (kind < 14) begin
        b = OpW'($urandom_range(1, 32767));
        a = b * OpW'($urandom_range(1, 32768));
      end else if (kind < 18) begin
        fa = 1;
        fb = 1;
        n  = $urandom_range(2, 45);
        for (int k = 0; k < n; k++) begin
          fc = fa + fb;
          fa = fb;
          fb = fc;
        end
        a = OpW'(fb);
        b = OpW'(fa);
      end else begin
        a = rand_operand();
        b = rand_operand();
      end
      if ($urandom_range(0, 1) != 0) begin
        {a, b} = {b, a};
      end
      gap = 0;
      if (i < NumRandom - QuietTail && ((i / 64) % 2) == 1 && $urandom_range(0, 2) == 0)
        gap = $urandom_range(1, 12);
      drain = (i == 0) || (i == NumRandom / 2) || ($urandom_range(0, 199) == 0);
      queue_pair(a, b, gap, drain);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all pairs sent and every result back, then watch for strays
    while (pending_pairs.size() != 0 || start || n_seen != n_taken) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);

    $display("tb: %0d operand pairs sent, %0d results checked, %0d mismatches",
             n_taken, n_seen, mismatches);
    $display("tb: longest Euclid chain %0d steps, %0d pairs with a zero operand",
             deepest, n_zero_op);
    if (mismatches == 0 && bezout_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
